// ===== rtl/core/tcgr_pkg.sv =====
// ---------------------------------------------------------------------------
// tcgr_pkg: shared types and constants for the text console glyph renderer
// Cursor and register widths, character codes, result kinds and the command
// record that passes from the front end to the back end.
// ---------------------------------------------------------------------------
package tcgr_pkg;

  localparam int CUR_W    = 13;
  localparam int OFF_W    = 26;
  localparam int MASK_W   = 8;
  localparam int COLOR_W  = 32;
  localparam int CODE_W   = 8;
  localparam int GLYPH_W  = 128;

  // Cursor steps, and the rows actually supplied with each glyph.
  localparam logic [CUR_W-1:0] GLYPH_HEIGHT = CUR_W'(16);
  localparam logic [CUR_W-1:0] GLYPH_WIDTH  = CUR_W'(8);
  localparam int GLYPH_ROWS = (int'(GLYPH_HEIGHT) < 16) ? int'(GLYPH_HEIGHT) : 16;
  localparam int ROW_CNT_W  = $clog2(GLYPH_ROWS);

  localparam int SCR_CNT_W = 2;

  localparam logic [CODE_W-1:0] CHAR_NUL     = 8'd0;
  localparam logic [CODE_W-1:0] CHAR_TAB     = 8'd9;
  localparam logic [CODE_W-1:0] CHAR_NEWLINE = 8'd10;

  localparam logic KIND_ROW    = 1'b0;
  localparam logic KIND_SCROLL = 1'b1;

  // Register map: index = byte address / 4.
  localparam int APB_ADDR_W = 4;
  localparam logic [1:0] REG_SCREEN_WIDTH  = 2'd0;
  localparam logic [1:0] REG_SCREEN_HEIGHT = 2'd1;
  localparam logic [1:0] REG_ROW_PITCH     = 2'd2;
  localparam logic [1:0] REG_FG_COLOR      = 2'd3;

  localparam logic [CUR_W-1:0]   RST_SCREEN_WIDTH  = CUR_W'(1024);
  localparam logic [CUR_W-1:0]   RST_SCREEN_HEIGHT = CUR_W'(768);
  localparam logic [CUR_W-1:0]   RST_ROW_PITCH     = CUR_W'(1024);
  localparam logic [COLOR_W-1:0] RST_FG_COLOR      = 32'h00FF_FFFF;

  localparam int CMDQ_DEPTH = 4;
  localparam int CMDQ_PTR_W = $clog2(CMDQ_DEPTH);

  typedef struct packed {
    logic [CUR_W-1:0]   screen_width;
    logic [CUR_W-1:0]   screen_height;
    logic [CUR_W-1:0]   row_pitch;
    logic [COLOR_W-1:0] fg_color;
  } tcgr_cfg_t;

  typedef struct packed {
    logic                 draw;
    logic [OFF_W-1:0]     base_off;
    logic [GLYPH_W-1:0]   glyph;
    logic [SCR_CNT_W-1:0] nscroll;
  } tcgr_cmd_t;

endpackage

// ===== rtl/core/tcgr_cfg.sv =====
// ---------------------------------------------------------------------------
// tcgr_cfg: configuration register file
// APB-style write and read access to the four console registers.
// ---------------------------------------------------------------------------
module tcgr_cfg (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_psel,
  input  logic                            cfg_penable,
  input  logic                            cfg_pwrite,
  input  logic [tcgr_pkg::APB_ADDR_W-1:0] cfg_paddr,
  input  logic [31:0]                     cfg_pwdata,
  output logic [31:0]                     cfg_prdata,
  output logic                            cfg_pready,
  output tcgr_pkg::tcgr_cfg_t             cfg_o
);
  import tcgr_pkg::*;

  tcgr_cfg_t  regs_r, regs_nxt;
  logic [1:0] idx;
  logic       wr_en;

  assign cfg_pready = 1'b1;
  assign idx        = cfg_paddr[APB_ADDR_W-1:2];
  assign wr_en      = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_o      = regs_r;

  always_comb begin
    regs_nxt = regs_r;
    if (wr_en) begin
      unique case (idx)
        REG_SCREEN_WIDTH:  regs_nxt.screen_width  = cfg_pwdata[CUR_W-1:0];
        REG_SCREEN_HEIGHT: regs_nxt.screen_height = cfg_pwdata[CUR_W-1:0];
        REG_ROW_PITCH:     regs_nxt.row_pitch     = cfg_pwdata[CUR_W-1:0];
        REG_FG_COLOR:      regs_nxt.fg_color      = cfg_pwdata;
        default:           regs_nxt = regs_r;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_SCREEN_WIDTH:  cfg_prdata = 32'(regs_r.screen_width);
      REG_SCREEN_HEIGHT: cfg_prdata = 32'(regs_r.screen_height);
      REG_ROW_PITCH:     cfg_prdata = 32'(regs_r.row_pitch);
      REG_FG_COLOR:      cfg_prdata = regs_r.fg_color;
      default:           cfg_prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      regs_r.screen_width  <= RST_SCREEN_WIDTH;
      regs_r.screen_height <= RST_SCREEN_HEIGHT;
      regs_r.row_pitch     <= RST_ROW_PITCH;
      regs_r.fg_color      <= RST_FG_COLOR;
    end else begin
      regs_r <= regs_nxt;
    end
  end

endmodule

// ===== rtl/core/tcgr_front.sv =====
// ---------------------------------------------------------------------------
// tcgr_front: character classifier and cursor keeper
// Accepts one character per cycle while the command queue is not full,
// moves the cursor and queues a command for every character with beats.
// ---------------------------------------------------------------------------
module tcgr_front (
  input  logic                        clk,
  input  logic                        rst_n,
  input  tcgr_pkg::tcgr_cfg_t         cfg_i,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [tcgr_pkg::CODE_W-1:0] char_code,
  input  logic [63:0]                 glyph_top,
  input  logic [63:0]                 glyph_bottom,
  output logic                        push,
  output tcgr_pkg::tcgr_cmd_t         push_cmd,
  input  logic                        q_full
);
  import tcgr_pkg::*;

  logic [CUR_W-1:0] cur_x_r, cur_x_nxt;
  logic [CUR_W-1:0] cur_y_r, cur_y_nxt;

  logic             accept;
  logic             is_nul, is_nl, is_draw;
  logic [CUR_W-1:0] y_nl, x1, y1, x2, y2, y3;
  logic             s1, s2, wrap;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;
  assign is_nul   = (char_code == CHAR_NUL);
  assign is_nl    = (char_code == CHAR_NEWLINE);
  assign is_draw  = !is_nul && !is_nl && (char_code != CHAR_TAB);

  // Comparisons are made one bit wider so that y+16 and x+8 do not wrap.
  always_comb begin
    y_nl = cur_y_r + GLYPH_HEIGHT;
    s1   = is_nl && (({1'b0, y_nl} + {1'b0, GLYPH_HEIGHT}) > {1'b0, cfg_i.screen_height});
    if (is_nl) begin
      x1 = '0;
      y1 = s1 ? (y_nl - GLYPH_HEIGHT) : y_nl;
    end else begin
      x1 = cur_x_r + GLYPH_WIDTH;
      y1 = cur_y_r;
    end
    wrap = ({1'b0, x1} + {1'b0, GLYPH_WIDTH}) > {1'b0, cfg_i.screen_width};
    x2   = wrap ? '0 : x1;
    y2   = wrap ? (y1 + GLYPH_HEIGHT) : y1;
    s2   = ({1'b0, y2} + {1'b0, GLYPH_HEIGHT}) > {1'b0, cfg_i.screen_height};
    y3   = s2 ? (y2 - GLYPH_HEIGHT) : y2;
  end

  always_comb begin
    push_cmd.draw     = is_draw;
    // Offset of the first glyph row; later rows add the pitch in the back end.
    push_cmd.base_off = OFF_W'(cur_y_r) * OFF_W'(cfg_i.row_pitch) + OFF_W'(cur_x_r);
    push_cmd.glyph    = {glyph_top, glyph_bottom};
    push_cmd.nscroll  = SCR_CNT_W'(s1) + SCR_CNT_W'(s2);
    push              = accept && !is_nul && (is_draw || s1 || s2);

    cur_x_nxt = cur_x_r;
    cur_y_nxt = cur_y_r;
    if (accept && !is_nul) begin
      cur_x_nxt = x2;
      cur_y_nxt = y3;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_x_r <= '0;
      cur_y_r <= '0;
    end else begin
      cur_x_r <= cur_x_nxt;
      cur_y_r <= cur_y_nxt;
    end
  end

endmodule

// ===== rtl/core/tcgr_cmdq.sv =====
// ---------------------------------------------------------------------------
// tcgr_cmdq: command queue
// Small register FIFO that decouples the classifier from the beat generator.
// ---------------------------------------------------------------------------
module tcgr_cmdq (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  tcgr_pkg::tcgr_cmd_t push_cmd,
  input  logic                pop,
  output tcgr_pkg::tcgr_cmd_t head_cmd,
  output logic                empty,
  output logic                full
);
  import tcgr_pkg::*;

  tcgr_cmd_t             entry_r [CMDQ_DEPTH];
  logic [CMDQ_PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [CMDQ_PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CMDQ_PTR_W:0]   count_r, count_nxt;
  logic                  do_push, do_pop;

  assign empty    = (count_r == '0);
  assign full     = (count_r == (CMDQ_PTR_W+1)'(CMDQ_DEPTH));
  assign head_cmd = entry_r[rd_ptr_r];
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;

  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_pop  ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r + (CMDQ_PTR_W+1)'(do_push) - (CMDQ_PTR_W+1)'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entry_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

// ===== rtl/core/tcgr_back.sv =====
// ---------------------------------------------------------------------------
// tcgr_back: result beat generator
// Plays out one queued command as glyph row writes and scroll requests,
// one beat per cycle unless stalled, into a registered output stage.
// ---------------------------------------------------------------------------
module tcgr_back (
  input  logic                         clk,
  input  logic                         rst_n,
  input  tcgr_pkg::tcgr_cfg_t          cfg_i,
  input  tcgr_pkg::tcgr_cmd_t          head_cmd,
  input  logic                         q_empty,
  output logic                         pop,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic                         out_kind,
  output logic [tcgr_pkg::OFF_W-1:0]   out_offset,
  output logic [tcgr_pkg::MASK_W-1:0]  out_mask,
  output logic [tcgr_pkg::COLOR_W-1:0] out_color,
  output logic                         out_last
);
  import tcgr_pkg::*;

  // Work on the current command
  logic                 draw_r, draw_nxt;
  logic [ROW_CNT_W-1:0] row_r, row_nxt;
  logic [SCR_CNT_W-1:0] scr_r, scr_nxt;
  logic [OFF_W-1:0]     off_r, off_nxt;
  logic [GLYPH_W-1:0]   glyph_r, glyph_nxt;

  // Output stage
  logic                 ov_r, ov_nxt;
  logic                 okind_r, okind_nxt;
  logic [OFF_W-1:0]     ooff_r, ooff_nxt;
  logic [MASK_W-1:0]    omask_r, omask_nxt;
  logic [COLOR_W-1:0]   ocolor_r, ocolor_nxt;
  logic                 olast_r, olast_nxt;

  logic busy, emit, beat_last, last_row;

  assign busy      = draw_r || (scr_r != '0);
  assign emit      = busy && (!ov_r || out_ready);
  assign last_row  = (row_r == ROW_CNT_W'(GLYPH_ROWS - 1));
  assign beat_last = draw_r ? (last_row && (scr_r == '0)) : (scr_r == SCR_CNT_W'(1));
  // The next command is taken as the last beat of the current one leaves.
  assign pop       = !q_empty && (!busy || (emit && beat_last));

  always_comb begin
    draw_nxt   = draw_r;
    row_nxt    = row_r;
    scr_nxt    = scr_r;
    off_nxt    = off_r;
    glyph_nxt  = glyph_r;
    ov_nxt     = ov_r;
    okind_nxt  = okind_r;
    ooff_nxt   = ooff_r;
    omask_nxt  = omask_r;
    ocolor_nxt = ocolor_r;
    olast_nxt  = olast_r;

    if (emit) begin
      ov_nxt    = 1'b1;
      olast_nxt = beat_last;
      if (draw_r) begin
        okind_nxt  = KIND_ROW;
        ooff_nxt   = off_r;
        omask_nxt  = glyph_r[GLYPH_W-1 -: MASK_W];
        ocolor_nxt = cfg_i.fg_color;
        glyph_nxt  = {glyph_r[GLYPH_W-MASK_W-1:0], MASK_W'(0)};
        off_nxt    = off_r + OFF_W'(cfg_i.row_pitch);
        row_nxt    = row_r + 1'b1;
        if (last_row) begin
          draw_nxt = 1'b0;
        end
      end else begin
        okind_nxt  = KIND_SCROLL;
        ooff_nxt   = '0;
        omask_nxt  = '0;
        ocolor_nxt = '0;
        scr_nxt    = scr_r - 1'b1;
      end
    end else if (out_ready) begin
      ov_nxt = 1'b0;
    end

    if (pop) begin
      draw_nxt  = head_cmd.draw;
      row_nxt   = '0;
      scr_nxt   = head_cmd.nscroll;
      off_nxt   = head_cmd.base_off;
      glyph_nxt = head_cmd.glyph;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      draw_r <= 1'b0;
      scr_r  <= '0;
      ov_r   <= 1'b0;
    end else begin
      draw_r <= draw_nxt;
      scr_r  <= scr_nxt;
      ov_r   <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    row_r    <= row_nxt;
    off_r    <= off_nxt;
    glyph_r  <= glyph_nxt;
    okind_r  <= okind_nxt;
    ooff_r   <= ooff_nxt;
    omask_r  <= omask_nxt;
    ocolor_r <= ocolor_nxt;
    olast_r  <= olast_nxt;
  end

  assign out_valid  = ov_r;
  assign out_kind   = okind_r;
  assign out_offset = ooff_r;
  assign out_mask   = omask_r;
  assign out_color  = ocolor_r;
  assign out_last   = olast_r;

endmodule

// ===== rtl/core/text_console_glyph_renderer_unit.sv =====
// ---------------------------------------------------------------------------
// text_console_glyph_renderer_unit: text console cursor and glyph writer
// Turns character beats with their 8x16 bitmaps into framebuffer row writes
// and scroll requests, keeping the pixel cursor.
//
//   channel | direction | beat contents
//   --------+-----------+----------------------------------------------------
//   in_     | slave     | char_code, glyph_top, glyph_bottom
//   out_    | master    | pixel_offset, row_mask, pixel_color; tuser kind; tlast
//   cfg_    | APB slave | screen_width, screen_height, row_pitch, fg_color
//
// A drawn character gives 16 row beats (17 with a scroll), back to back
// while the output is ready; a newline gives up to two scroll beats, a tab
// at most one, code zero none. The output channel sets the rate of drawn
// characters. A four-entry command queue lets characters be taken back to
// back while beats drain. From idle the first beat of an accepted character
// passes through the command queue, the beat generator and the output stage;
// behind a busy generator it follows the previous last beat with no gap.
// Reset is synchronous and clears the cursor, queue and output stage.
// ---------------------------------------------------------------------------
module text_console_glyph_renderer_unit (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // [7:0] char_code, [71:8] glyph_top, [135:72] glyph_bottom
  input  logic [135:0]                    in_tdata,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // [25:0] pixel_offset, [33:26] row_mask, [65:34] pixel_color, [71:66] zero
  output logic [71:0]                     out_tdata,
  // [0] kind
  output logic [0:0]                      out_tuser,
  output logic                            out_tlast,
  input  logic                            cfg_psel,
  input  logic                            cfg_penable,
  input  logic                            cfg_pwrite,
  input  logic [tcgr_pkg::APB_ADDR_W-1:0] cfg_paddr,
  input  logic [31:0]                     cfg_pwdata,
  output logic [31:0]                     cfg_prdata,
  output logic                            cfg_pready
);
  import tcgr_pkg::*;

  tcgr_cfg_t          cfg;
  tcgr_cmd_t          push_cmd, head_cmd;
  logic               push, pop, q_empty, q_full;
  logic               o_kind;
  logic [OFF_W-1:0]   o_off;
  logic [MASK_W-1:0]  o_mask;
  logic [COLOR_W-1:0] o_color;

  tcgr_cfg u_cfg (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .cfg_o       (cfg)
  );

  tcgr_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_i        (cfg),
    .in_valid     (in_tvalid),
    .in_ready     (in_tready),
    .char_code    (in_tdata[7:0]),
    .glyph_top    (in_tdata[71:8]),
    .glyph_bottom (in_tdata[135:72]),
    .push         (push),
    .push_cmd     (push_cmd),
    .q_full       (q_full)
  );

  tcgr_cmdq u_cmdq (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .head_cmd (head_cmd),
    .empty    (q_empty),
    .full     (q_full)
  );

  tcgr_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_i      (cfg),
    .head_cmd   (head_cmd),
    .q_empty    (q_empty),
    .pop        (pop),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .out_kind   (o_kind),
    .out_offset (o_off),
    .out_mask   (o_mask),
    .out_color  (o_color),
    .out_last   (out_tlast)
  );

  assign out_tdata = {6'b0, o_color, o_mask, o_off};
  assign out_tuser = o_kind;

endmodule

// ===== rtl/core/tcgr_checker.sv =====
// ---------------------------------------------------------------------------
// tcgr_checker: port-level checks for the glyph renderer
// Checks result stalls, scroll contents, gaps, reset state and cfg ready.
// ---------------------------------------------------------------------------
module tcgr_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [71:0] out_tdata,
  input logic [0:0]  out_tuser,
  input logic        out_tlast,
  input logic        cfg_psel,
  input logic        cfg_penable,
  input logic        cfg_pready
);
  import tcgr_pkg::*;

  // A stalled beat holds.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("result beat changed while stalled");

  // Scroll requests carry no offset, mask or colour.
  a_scroll_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser[0] == KIND_SCROLL) |-> (out_tdata == '0))
    else $error("scroll beat with nonzero data");

  // Beats of one character follow each other without a gap.
  a_no_gap: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tready && !out_tlast |=> out_tvalid)
    else $error("gap inside a character's beats");

  // Nothing is offered in the cycle after reset.
  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid right after reset");

  // The configuration port never waits.
  a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_psel && cfg_penable |-> cfg_pready)
    else $error("configuration access stalled");

endmodule

bind text_console_glyph_renderer_unit tcgr_checker u_tcgr_checker (.*);

// ===== test/text_console_glyph_renderer_unit_test.sv =====
// ---------------------------------------------------------------------------
// text_console_glyph_renderer_unit_test: self-checking bench for the glyph writer
// Characters with random bitmaps are streamed in while a cursor model works
// out the row writes and scroll requests that each one must cause. Output
// beats are compared field by field against that list in order. Screen
// geometry and colour are reprogrammed over APB between phases, and both
// stream sides idle at random, with one long output hold-off.
// ---------------------------------------------------------------------------
module text_console_glyph_renderer_unit_test;
  import tcgr_pkg::*;

  localparam int HOLD_CYCLES   = 400;
  localparam int SETTLE_CYCLES = 40;
  localparam int MAX_PRINTED   = 40;

  typedef struct packed {
    logic               kind;
    logic [OFF_W-1:0]   offset;
    logic [MASK_W-1:0]  mask;
    logic [COLOR_W-1:0] color;
    logic               last;
  } fb_write_t;

  logic         clk;
  logic         rst_n       = 1'b0;
  logic         in_tvalid   = 1'b0;
  logic         in_tready;
  logic [135:0] in_tdata    = '0;
  logic         out_tvalid;
  logic         out_tready  = 1'b0;
  logic [71:0]  out_tdata;
  logic [0:0]   out_tuser;
  logic         out_tlast;
  logic         cfg_psel    = 1'b0;
  logic         cfg_penable = 1'b0;
  logic         cfg_pwrite  = 1'b0;
  logic [APB_ADDR_W-1:0] cfg_paddr = '0;
  logic [31:0]  cfg_pwdata  = '0;
  logic [31:0]  cfg_prdata;
  logic         cfg_pready;

  // Cursor model and its copy of the registers.
  logic [CUR_W-1:0]   cur_x = '0;
  logic [CUR_W-1:0]   cur_y = '0;
  logic [CUR_W-1:0]   scr_w = RST_SCREEN_WIDTH;
  logic [CUR_W-1:0]   scr_h = RST_SCREEN_HEIGHT;
  logic [CUR_W-1:0]   pitch = RST_ROW_PITCH;
  logic [COLOR_W-1:0] fg    = RST_FG_COLOR;

  logic [135:0] pending_chars[$];
  fb_write_t    fb_writes_due[$];

  int tx_idle_pct = 16;
  int rx_idle_pct = 76;
  int err_count   = 0;
  int chars_taken = 0;
  int rows_seen   = 0;
  int scrolls_seen = 0;

  logic hold_trig = 1'b0;
  logic hold_done = 1'b0;
  int   hold_left = 0;

  text_console_glyph_renderer_unit dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_prdata (cfg_prdata),
    .cfg_pready (cfg_pready)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #3000000;
    $display("Verification failed");
    $finish;
  end

  task automatic report_mismatch(input string msg);
    if (err_count < MAX_PRINTED) $display("%0t ERROR %s", $time, msg);
    err_count++;
  endtask

  function void push_write(input logic kind, input logic [OFF_W-1:0] offset,
                           input logic [MASK_W-1:0] mask, input logic [COLOR_W-1:0] color);
    fb_writes_due.push_back('{kind: kind, offset: offset, mask: mask, color: color,
                              last: 1'b0});
  endfunction

  // The comparison is done at full width, so a cursor near the top of the
  // 13-bit range never wraps past the test.
  function void check_scroll();
    if (int'(cur_y) + int'(GLYPH_HEIGHT) > int'(scr_h)) begin
      push_write(KIND_SCROLL, '0, '0, '0);
      cur_y = cur_y - GLYPH_HEIGHT;
    end
  endfunction

  function void render_char(input logic [135:0] beat);
    logic [CODE_W-1:0]  code;
    logic [63:0]        top;
    logic [63:0]        bottom;
    logic [MASK_W-1:0]  bits;
    longint unsigned    full;
    int                 first;
    code   = beat[7:0];
    top    = beat[71:8];
    bottom = beat[135:72];
    first  = fb_writes_due.size();
    chars_taken++;
    if (code == CHAR_NUL) return;
    if (code == CHAR_NEWLINE) begin
      cur_x = '0;
      cur_y = cur_y + GLYPH_HEIGHT;
      check_scroll();
    end else if (code == CHAR_TAB) begin
      cur_x = cur_x + GLYPH_WIDTH;
    end else begin
      for (int r = 0; r < GLYPH_ROWS; r++) begin
        bits = (r < 8) ? top[63 - 8*r -: 8] : bottom[63 - 8*(r-8) -: 8];
        full = (longint'(cur_y) + r) * longint'(pitch) + longint'(cur_x);
        push_write(KIND_ROW, full[OFF_W-1:0], bits, fg);
      end
      cur_x = cur_x + GLYPH_WIDTH;
    end
    if (int'(cur_x) + int'(GLYPH_WIDTH) > int'(scr_w)) begin
      cur_x = '0;
      cur_y = cur_y + GLYPH_HEIGHT;
    end
    check_scroll();
    if (fb_writes_due.size() > first) fb_writes_due[fb_writes_due.size()-1].last = 1'b1;
  endfunction

  // Input side: a beat is held until taken; new beats are offered only when
  // the slot is free and the idle roll allows.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) render_char(in_tdata);
      if (!in_tvalid || in_tready) begin
        if (pending_chars.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
          in_tvalid <= 1'b1;
          in_tdata  <= pending_chars.pop_front();
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      hold_left <= 0;
    end else if (hold_trig && !hold_done) begin
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  always @(posedge clk) begin : watch_out
    fb_write_t want;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      out_tready <= (hold_left == 0) && ($urandom_range(99) >= rx_idle_pct);
      if (out_tvalid && out_tready) begin
        if (fb_writes_due.size() == 0) begin
          report_mismatch($sformatf("beat with nothing expected: tuser=%b tdata=%h last=%b",
                                    out_tuser, out_tdata, out_tlast));
        end else begin
          want = fb_writes_due.pop_front();
          if (out_tuser[0] !== want.kind)
            report_mismatch($sformatf("kind %b, expected %b", out_tuser[0], want.kind));
          if (out_tdata[25:0] !== want.offset)
            report_mismatch($sformatf("pixel offset %0d, expected %0d",
                                      out_tdata[25:0], want.offset));
          if (out_tdata[33:26] !== want.mask)
            report_mismatch($sformatf("row mask %h, expected %h",
                                      out_tdata[33:26], want.mask));
          if (out_tdata[65:34] !== want.color)
            report_mismatch($sformatf("colour %h, expected %h",
                                      out_tdata[65:34], want.color));
          if (out_tlast !== want.last)
            report_mismatch($sformatf("last %b, expected %b", out_tlast, want.last));
          if (want.kind == KIND_SCROLL) scrolls_seen++;
          else rows_seen++;
        end
      end
    end
  end

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
    @(posedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    case (idx)
      REG_SCREEN_WIDTH:  scr_w = value[CUR_W-1:0];
      REG_SCREEN_HEIGHT: scr_h = value[CUR_W-1:0];
      REG_ROW_PITCH:     pitch = value[CUR_W-1:0];
      REG_FG_COLOR:      fg    = value;
      default: ;
    endcase
  endtask

  task automatic apply_screen(input int w, input int h, input int p, input logic [31:0] c);
    write_reg(REG_SCREEN_WIDTH, w);
    write_reg(REG_SCREEN_HEIGHT, h);
    write_reg(REG_ROW_PITCH, p);
    write_reg(REG_FG_COLOR, c);
  endtask

  task automatic queue_char(input logic [7:0] code, input logic [63:0] top,
                            input logic [63:0] bottom);
    pending_chars.push_back({bottom, top, code});
  endtask

  // Mostly drawn characters, with enough newlines and tabs to keep the
  // cursor wrapping and scrolling on the small screens used here.
  task automatic queue_random_char();
    int sel;
    logic [7:0] code;
    sel = $urandom_range(99);
    if (sel < 10) code = CHAR_NEWLINE;
    else if (sel < 20) code = CHAR_TAB;
    else if (sel < 24) code = CHAR_NUL;
    else code = 8'($urandom_range(255));
    queue_char(code, {$urandom, $urandom}, {$urandom, $urandom});
  endtask

  // Characters that cause no beat may still be in flight once the last
  // expected beat is out, hence the pause before any register write.
  task automatic wait_drained();
    do @(negedge clk);
    while (pending_chars.size() != 0 || in_tvalid || fb_writes_due.size() != 0);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  initial begin : stimulus
    int w;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // Narrow, short screen: wraps and scrolls within a handful of characters.
    apply_screen(24, 32, 24, 32'h0000_0000);
    queue_char(CHAR_NUL, {$urandom, $urandom}, {$urandom, $urandom});
    queue_char(8'hFF, '1, '0);
    queue_char(8'h01, '0, '1);
    queue_char(CHAR_TAB, '1, '1);
    queue_char(8'h0B, 64'hAAAA_AAAA_AAAA_AAAA, 64'h5555_5555_5555_5555);
    queue_char(CHAR_NEWLINE, '0, '0);
    queue_char(CHAR_TAB, '0, '0);
    queue_char(CHAR_TAB, '0, '0);
    queue_char(8'h08, 64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA);
    queue_char(CHAR_NUL, '1, '1);
    wait_drained();

    // The cursor now sits one line down; shrinking the screen to a single
    // line makes the next newline scroll twice.
    write_reg(REG_SCREEN_HEIGHT, 16);
    queue_char(CHAR_NEWLINE, {$urandom, $urandom}, {$urandom, $urandom});
    wait_drained();

    apply_screen(8191, 8191, 8191, 32'hFFFF_FFFF);
    queue_char(8'h80, {$urandom, $urandom}, {$urandom, $urandom});
    queue_char(CHAR_TAB, '0, '0);
    queue_char(8'h7F, {$urandom, $urandom}, {$urandom, $urandom});
    queue_char(CHAR_NEWLINE, '0, '0);
    queue_char(8'h41, 64'h0123_4567_89AB_CDEF, 64'hFEDC_BA98_7654_3210);
    wait_drained();

    // Minimum width: every character forces a line wrap.
    write_reg(REG_SCREEN_WIDTH, 8);
    queue_char(8'h20, {$urandom, $urandom}, {$urandom, $urandom});
    queue_char(8'hFE, {$urandom, $urandom}, {$urandom, $urandom});
    queue_char(CHAR_TAB, '0, '0);
    wait_drained();

    apply_screen($urandom_range(8, 120), $urandom_range(16, 96),
                 $urandom_range(8, 8191), $urandom);
    repeat (65) queue_random_char();
    wait_drained();

    tx_idle_pct = 76;
    rx_idle_pct = 16;
    apply_screen($urandom_range(8, 200), $urandom_range(16, 160),
                 $urandom_range(8, 8191), $urandom);
    repeat (65) queue_random_char();
    wait_drained();

    // No idling, and one long output hold-off so the command queue fills
    // and the input side backs up.
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    w = $urandom_range(64, 512);
    apply_screen(w, $urandom_range(16, 8191), $urandom_range(w, 8191), $urandom);
    hold_trig <= 1'b1;
    repeat (60) queue_random_char();
    wait_drained();

    if (fb_writes_due.size() != 0)
      report_mismatch($sformatf("%0d expected beats never arrived", fb_writes_due.size()));
    $display("Summary: %0d characters taken; %0d row writes and %0d scroll requests checked.",
             chars_taken, rows_seen, scrolls_seen);
    $display("Screens from 8 to 8191 pixels, three idling mixes and a %0d-cycle hold-off.",
             HOLD_CYCLES);
    if (err_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
